// ===== rtl/lfu_pkg.sv =====
// Shared constants and types for the LFU cache table.
package lfu_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int STAMP_WIDTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CAP_W       = 5;
    localparam int DATA_W      = 32;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = {STAMP_WIDTH{1'b1}};
    localparam logic [DATA_W-1:0]      NOT_FOUND = {DATA_W{1'b1}};
    localparam logic [CAP_W-1:0]       CAP_LIMIT = CAP_W'(TABLE_DEPTH);

    localparam logic [1:0] OP_GET     = 2'd0;
    localparam logic [1:0] OP_PUT     = 2'd1;
    localparam logic [1:0] OP_PUT_NOP = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } t_req;

endpackage

// ===== rtl/lfu_req_fifo.sv =====
// Small request queue between the classifying front and the table engine.
module lfu_req_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lfu_pkg::t_req i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lfu_pkg::t_req o_data
);
    import lfu_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_req             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    ap_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("pop from empty queue");
    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PTR_W+1)'(FIFO_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/lfu_engine.sv =====
// Table engine: scans the entries, picks hit, victim or free slot, writes back.
module lfu_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  lfu_pkg::t_req              i_req,
    output logic                       o_req_pop,
    input  logic [lfu_pkg::CAP_W-1:0]  i_cap,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_found,
    output logic [lfu_pkg::DATA_W-1:0] o_read_value
);
    import lfu_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic                   r_valid [TABLE_DEPTH];
    logic [DATA_W-1:0]      r_key   [TABLE_DEPTH];
    logic [DATA_W-1:0]      r_value [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] r_count [TABLE_DEPTH];
    logic [STAMP_WIDTH-1:0] r_stamp [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_valid_vec;

    logic [1:0]             r_state;
    logic [IDX_W-1:0]       r_idx;
    t_req                   r_req;
    logic [CAP_W-1:0]       r_occ;
    logic [STAMP_WIDTH-1:0] r_stamp_ctr;

    logic                   r_hit_v;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [DATA_W-1:0]      r_hit_value;
    logic [COUNT_WIDTH-1:0] r_hit_count;
    logic                   r_vic_v;
    logic [IDX_W-1:0]       r_vic_idx;
    logic [COUNT_WIDTH-1:0] r_vic_count;
    logic [STAMP_WIDTH-1:0] r_vic_stamp;
    logic                   r_free_v;
    logic [IDX_W-1:0]       r_free_idx;

    logic                   r_ovalid;
    logic                   r_ofound;
    logic [DATA_W-1:0]      r_ovalue;

    logic                   w_e_valid;
    logic                   w_match;
    logic                   w_better;
    logic                   w_out_free;
    logic                   w_do_write;
    logic                   w_ins;
    logic                   w_ins_free;
    logic [IDX_W-1:0]       w_ins_idx;
    logic                   w_touch;

    assign w_e_valid  = r_valid[r_idx];
    assign w_match    = w_e_valid && (r_key[r_idx] == r_req.key);
    assign w_better   = w_e_valid && (!r_vic_v || (r_count[r_idx] < r_vic_count) ||
                        ((r_count[r_idx] == r_vic_count) && (r_stamp[r_idx] < r_vic_stamp)));
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_do_write = (r_state == ST_WRITE) && w_out_free;
    assign o_req_pop  = (r_state == ST_IDLE) && i_req_valid;

    always_comb begin
        w_ins      = 1'b0;
        w_ins_free = 1'b0;
        w_ins_idx  = r_free_idx;
        w_touch    = r_hit_v && (r_req.op != OP_PUT_NOP);
        if (r_req.op == OP_PUT && !r_hit_v) begin
            if (r_occ >= i_cap && r_vic_v) begin
                w_ins     = 1'b1;
                w_ins_idx = r_vic_idx;
            end else if (r_free_v) begin
                w_ins      = 1'b1;
                w_ins_free = 1'b1;
            end
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_vec
        assign w_valid_vec[g] = r_valid[g];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_stamp_ctr <= '0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            if (w_do_write) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req_valid) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_idx == IDX_W'(TABLE_DEPTH-1)) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (w_out_free) begin
                        r_state  <= ST_IDLE;
                        if (w_touch || w_ins) begin
                            if (r_stamp_ctr != STAMP_MAX) begin
                                r_stamp_ctr <= r_stamp_ctr + 1'b1;
                            end
                        end
                        if (w_ins) begin
                            r_valid[w_ins_idx] <= 1'b1;
                        end
                        if (w_ins_free) begin
                            r_occ <= r_occ + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_req    <= i_req;
            r_idx    <= '0;
            r_hit_v  <= 1'b0;
            r_vic_v  <= 1'b0;
            r_free_v <= 1'b0;
        end else if (r_state == ST_SCAN) begin
            r_idx <= r_idx + 1'b1;
            if (w_match && !r_hit_v) begin
                r_hit_v     <= 1'b1;
                r_hit_idx   <= r_idx;
                r_hit_value <= r_value[r_idx];
                r_hit_count <= r_count[r_idx];
            end
            if (w_better) begin
                r_vic_v     <= 1'b1;
                r_vic_idx   <= r_idx;
                r_vic_count <= r_count[r_idx];
                r_vic_stamp <= r_stamp[r_idx];
            end
            if (!w_e_valid && !r_free_v) begin
                r_free_v   <= 1'b1;
                r_free_idx <= r_idx;
            end
        end
        if (w_do_write) begin
            r_ofound <= r_hit_v && (r_req.op != OP_PUT_NOP);
            r_ovalue <= (r_hit_v && r_req.op == OP_GET) ? r_hit_value : NOT_FOUND;
            if (w_touch) begin
                r_count[r_hit_idx] <= (r_hit_count == COUNT_MAX) ?
                                      r_hit_count : r_hit_count + 1'b1;
                r_stamp[r_hit_idx] <= r_stamp_ctr;
                if (r_req.op == OP_PUT) begin
                    r_value[r_hit_idx] <= r_req.value;
                end
            end
            if (w_ins) begin
                r_key[w_ins_idx]   <= r_req.key;
                r_value[w_ins_idx] <= r_req.value;
                r_count[w_ins_idx] <= COUNT_WIDTH'(1);
                r_stamp[w_ins_idx] <= r_stamp_ctr;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_found      = r_ofound;
    assign o_read_value = r_ovalue;

`ifndef SYNTHESIS
    ap_occ_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_occ)) else $error("occupancy mismatch");
    ap_stamp_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stamp_ctr >= $past(r_stamp_ctr)) else $error("stamp counter went back");
    ap_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && r_hit_v) |-> r_valid[r_hit_idx])
        else $error("hit on invalid entry");
    ap_write_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_write |=> (r_state == ST_IDLE && r_ovalid)) else $error("write did not respond");
`endif

endmodule

// ===== rtl/lfu_cache_table.sv =====
// Top level of the LFU cache table: request front, queue and table engine.
// A request passes the queue, is popped by the idle engine, scans all 16 table entries
// and is then written back; the write-back waits while the previous response is stalled.
// The engine takes one request at a time: it pops the next only after the scan and write-back.
// Reset (synchronous, active low): all entries invalid, occupancy and stamp zero,
// capacity 16, queue empty, no response pending.
module lfu_cache_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_req_valid,
    output logic                       o_req_stall,
    input  logic                       i_kind,
    input  logic [lfu_pkg::DATA_W-1:0] i_lookup_key,
    input  logic [lfu_pkg::DATA_W-1:0] i_store_value,
    // response channel
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_stall,
    output logic                       o_found,
    output logic [lfu_pkg::DATA_W-1:0] o_read_value,
    // capacity register write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]  i_cfg_entries_in_use
);
    import lfu_pkg::*;

    logic [CAP_W-1:0] r_cap_cfg;
    logic [CAP_W-1:0] w_cap;
    logic             w_full;
    logic             w_push;
    t_req             w_req_in;
    logic             w_q_valid;
    t_req             w_q_data;
    logic             w_pop;

    // Config register is always writable; user must write it only while idle (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg <= CAP_LIMIT;
        end else if (i_cfg_valid) begin
            r_cap_cfg <= i_cfg_entries_in_use;
        end
    end

    // Clamp capacity to the table depth.
    assign w_cap = (r_cap_cfg > CAP_LIMIT) ? CAP_LIMIT : r_cap_cfg;

    // Front: classify the request; a put with zero capacity becomes a no-op.
    always_comb begin
        w_req_in.key   = i_lookup_key;
        w_req_in.value = i_store_value;
        if (!i_kind) begin
            w_req_in.op = OP_GET;
        end else if (w_cap == '0) begin
            w_req_in.op = OP_PUT_NOP;
        end else begin
            w_req_in.op = OP_PUT;
        end
    end

    // Stall the request side only when the queue is full.
    assign o_req_stall = w_full;
    assign w_push      = i_req_valid && !w_full;

    lfu_req_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_req_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // Back: scan the table and answer each request in order.
    lfu_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (w_q_valid),
        .i_req        (w_q_data),
        .o_req_pop    (w_pop),
        .i_cap        (w_cap),
        .o_valid      (o_rsp_valid),
        .i_stall      (i_rsp_stall),
        .o_found      (o_found),
        .o_read_value (o_read_value)
    );

endmodule
